// ===== src/bmm_pkg.sv =====
// ----------------------------------------------------------------------------
// bmm_pkg
// Shared types and constants of the banked memory mapper: word formats,
// region codes, control register indexes, controller states and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package bmm_pkg;

	// memory sizes and page count limit
	localparam int RAM_BYTES     = 8192;
	localparam int SRAM_BYTES    = 32768;
	localparam int MAX_ROM_PAGES = 256;

	localparam int ADDR_W   = 16;
	localparam int DATA_W   = 8;
	localparam int OFFS_W   = 22;
	localparam int PAGES_W  = 9;
	localparam int PAGE_W   = 8;
	localparam int SLOT_W   = 13;
	localparam int ROM_OFS_W = 14;
	localparam int DIV_STEPS = DATA_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	localparam logic [ADDR_W-1:0] CTRL_BASE  = 16'hFFFC;
	localparam logic [ADDR_W-1:0] SLOT_MASK  = 16'h1FFF;
	localparam logic [ADDR_W-1:0] SRAM_UPPER = 16'h4000;
	localparam logic [ADDR_W-1:0] SLOT_HALF  = 16'h2000;
	localparam logic [DATA_W-1:0] SRAM_ON    = 8'h08;
	localparam logic [DATA_W-1:0] SRAM_HIGH  = 8'h04;

	// region codes
	localparam logic [1:0] REGION_ROM     = 2'd0;
	localparam logic [1:0] REGION_SRAM    = 2'd1;
	localparam logic [1:0] REGION_RAM     = 2'd2;
	localparam logic [1:0] REGION_DISCARD = 2'd3;

	// control register indexes (address & 3)
	localparam logic [1:0] CREG_RAM_CTRL = 2'd0;
	localparam logic [1:0] CREG_PAGE0    = 2'd1;
	localparam logic [1:0] CREG_PAGE1    = 2'd2;
	localparam logic [1:0] CREG_PAGE2    = 2'd3;

	// slot pair page indexes
	localparam logic [1:0] PAIR_LOW  = 2'd0;
	localparam logic [1:0] PAIR_MID  = 2'd1;
	localparam logic [1:0] PAIR_HIGH = 2'd2;

	// reduced page reset values
	localparam logic [PAGE_W-1:0] PAGE_LOW_RST  = 8'd0;
	localparam logic [PAGE_W-1:0] PAGE_MID_RST  = 8'd1;
	localparam logic [PAGE_W-1:0] PAGE_HIGH_RST = 8'd0;

	typedef struct packed {
		logic              kind;
		logic [ADDR_W-1:0] address;
		logic [DATA_W-1:0] write_data;
	} in_word_t;

	typedef struct packed {
		logic [1:0]        region;
		logic [OFFS_W-1:0] offset;
		logic              store_enable;
		logic              sram_used;
	} out_word_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIVIDE,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic accept;
		logic div_step;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic need_div;
		logic div_last;
	} status_t;

endpackage

// ===== src/bmm_ctrl.sv =====
// ----------------------------------------------------------------------------
// bmm_ctrl
// Controller of the banked memory mapper: takes an input word, runs the
// page remainder when a control register is loaded, and hands the result
// to the output register.
// ----------------------------------------------------------------------------
module bmm_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	output logic             out_valid,
	input  logic             out_stall,
	input  bmm_pkg::status_t status,
	output bmm_pkg::cmd_t    cmd
);

	bmm_pkg::state_t state_q;
	bmm_pkg::state_t state_nxt;
	logic            out_valid_q;
	logic            out_free;

	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			bmm_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_nxt = status.need_div ? bmm_pkg::ST_DIVIDE : bmm_pkg::ST_EMIT;
				end
			end
			bmm_pkg::ST_DIVIDE: begin
				if (status.div_last) begin
					state_nxt = bmm_pkg::ST_EMIT;
				end
			end
			bmm_pkg::ST_EMIT: begin
				if (out_free) begin
					state_nxt = bmm_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nxt = bmm_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_stall     = 1'b1;
		cmd.accept   = 1'b0;
		cmd.div_step = 1'b0;
		cmd.emit     = 1'b0;
		case (state_q)
			bmm_pkg::ST_IDLE: begin
				in_stall   = 1'b0;
				cmd.accept = in_valid;
			end
			bmm_pkg::ST_DIVIDE: begin
				cmd.div_step = 1'b1;
			end
			bmm_pkg::ST_EMIT: begin
				cmd.emit = out_free;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bmm_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	// a loaded result is shown in the next cycle
	a_emit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> out_valid_q)
		else $error("result not shown after emit");

	// a waiting result is never dropped
	a_out_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_stall |=> out_valid_q)
		else $error("stalled result dropped");

	// no new word is taken until the previous one has left the controller
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |=> in_stall)
		else $error("input taken while busy");

	// the remainder runs its full count before the result moves on
	a_divide_len: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == bmm_pkg::ST_DIVIDE && !status.div_last |=>
		state_q == bmm_pkg::ST_DIVIDE)
		else $error("remainder cut short");

endmodule

// ===== src/bmm_dp.sv =====
// ----------------------------------------------------------------------------
// bmm_dp
// Datapath of the banked memory mapper: slot decode, control registers,
// reduced page registers, a one-bit-per-cycle restoring remainder unit and
// the pending and output word registers.
// ----------------------------------------------------------------------------
module bmm_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	input  logic [bmm_pkg::PAGES_W-1:0]       cfg_data,
	input  bmm_pkg::in_word_t                 in_data,
	output bmm_pkg::out_word_t                out_data,
	input  bmm_pkg::cmd_t                     cmd,
	output bmm_pkg::status_t                  status
);

	localparam logic [bmm_pkg::DIV_CNT_W-1:0] CNT_LAST =
		bmm_pkg::DIV_CNT_W'(bmm_pkg::DIV_STEPS - 1);

	logic [bmm_pkg::PAGES_W-1:0] rom_pages_q;
	logic [bmm_pkg::DATA_W-1:0]  fc0_q;
	logic [bmm_pkg::DATA_W-1:0]  fc3_q;
	logic [bmm_pkg::PAGE_W-1:0]  page_q [3];
	logic                        sram_seen_q;

	logic [bmm_pkg::DATA_W-1:0]    dvd_q;
	logic [bmm_pkg::PAGE_W-1:0]    rem_q;
	logic [bmm_pkg::PAGES_W-1:0]   dsr_q;
	logic [bmm_pkg::DIV_CNT_W-1:0] cnt_q;
	logic [1:0]                    tgt_q;

	bmm_pkg::out_word_t pend_q;
	bmm_pkg::out_word_t out_q;

	// decode of the incoming word
	logic [2:0]                  slot;
	logic [bmm_pkg::ADDR_W-1:0]  slot_ofs;
	logic [1:0]                  creg;
	logic                        ctrl_wr;
	logic                        sram_on;
	logic [bmm_pkg::ADDR_W-1:0]  sram_sum;
	logic [bmm_pkg::PAGE_W-1:0]  rom_page;
	logic [bmm_pkg::PAGES_W-1:0] pages_eff;
	logic                        seen_nxt;
	bmm_pkg::out_word_t          res;

	// remainder step
	logic [bmm_pkg::PAGES_W-1:0] trial;
	logic                        fits;
	logic [bmm_pkg::PAGE_W-1:0]  rem_nxt;

	assign slot     = in_data.address[15:13];
	assign slot_ofs = in_data.address & bmm_pkg::SLOT_MASK;
	assign creg     = in_data.address[1:0];
	assign ctrl_wr  = in_data.kind && (in_data.address >= bmm_pkg::CTRL_BASE);
	assign sram_on  = (fc0_q & bmm_pkg::SRAM_ON) != '0;

	always_comb begin
		case (slot[2:1])
			bmm_pkg::PAIR_LOW:  rom_page = page_q[0];
			bmm_pkg::PAIR_MID:  rom_page = page_q[1];
			bmm_pkg::PAIR_HIGH: rom_page = page_q[2];
			default:            rom_page = page_q[2];
		endcase
	end

	assign sram_sum = (((fc0_q & bmm_pkg::SRAM_HIGH) != '0) ? bmm_pkg::SRAM_UPPER : '0)
		+ (slot[0] ? bmm_pkg::SLOT_HALF : '0) + slot_ofs;

	// zero pages act as one, counts above the maximum are clipped
	always_comb begin
		if (rom_pages_q == '0) begin
			pages_eff = bmm_pkg::PAGES_W'(1);
		end else if (rom_pages_q > bmm_pkg::PAGES_W'(bmm_pkg::MAX_ROM_PAGES)) begin
			pages_eff = bmm_pkg::PAGES_W'(bmm_pkg::MAX_ROM_PAGES);
		end else begin
			pages_eff = rom_pages_q;
		end
	end

	assign seen_nxt = sram_seen_q || (ctrl_wr && creg == bmm_pkg::CREG_RAM_CTRL
		&& (in_data.write_data & bmm_pkg::SRAM_ON) != '0);

	always_comb begin
		res.store_enable = 1'b0;
		res.sram_used    = seen_nxt;
		if (slot >= 3'd6) begin
			res.region       = bmm_pkg::REGION_RAM;
			res.offset       = bmm_pkg::OFFS_W'(32'(slot_ofs) % bmm_pkg::RAM_BYTES);
			res.store_enable = in_data.kind;
		end else if (slot >= 3'd4 && sram_on) begin
			res.region       = bmm_pkg::REGION_SRAM;
			res.offset       = bmm_pkg::OFFS_W'(32'(sram_sum) % bmm_pkg::SRAM_BYTES);
			res.store_enable = in_data.kind;
		end else if (in_data.kind) begin
			res.region = bmm_pkg::REGION_DISCARD;
			res.offset = '0;
		end else begin
			res.region = bmm_pkg::REGION_ROM;
			res.offset = {rom_page, in_data.address[bmm_pkg::ROM_OFS_W-1:0]};
		end
	end

	// register 0 with save ram on, or register 3 while save ram is on, leave pages alone
	assign status.need_div = ctrl_wr
		&& !(creg == bmm_pkg::CREG_RAM_CTRL && (in_data.write_data & bmm_pkg::SRAM_ON) != '0)
		&& !(creg == bmm_pkg::CREG_PAGE2 && sram_on);
	assign status.div_last = cnt_q == CNT_LAST;

	assign trial   = {rem_q, dvd_q[bmm_pkg::DATA_W-1]};
	assign fits    = trial >= dsr_q;
	assign rem_nxt = fits ? bmm_pkg::PAGE_W'(trial - dsr_q) : bmm_pkg::PAGE_W'(trial);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rom_pages_q <= bmm_pkg::PAGES_W'(1);
			fc0_q       <= '0;
			fc3_q       <= '0;
			page_q[0]   <= bmm_pkg::PAGE_LOW_RST;
			page_q[1]   <= bmm_pkg::PAGE_MID_RST;
			page_q[2]   <= bmm_pkg::PAGE_HIGH_RST;
			sram_seen_q <= 1'b0;
			cnt_q       <= '0;
		end else begin
			if (cfg_valid) begin
				rom_pages_q <= cfg_data;
			end
			if (cmd.accept) begin
				sram_seen_q <= seen_nxt;
				cnt_q       <= '0;
				if (ctrl_wr && creg == bmm_pkg::CREG_RAM_CTRL) begin
					fc0_q <= in_data.write_data;
				end
				if (ctrl_wr && creg == bmm_pkg::CREG_PAGE2) begin
					fc3_q <= in_data.write_data;
				end
			end
			if (cmd.div_step) begin
				cnt_q <= cnt_q + 1'b1;
				if (status.div_last) begin
					case (tgt_q)
						bmm_pkg::PAIR_LOW:  page_q[0] <= rem_nxt;
						bmm_pkg::PAIR_MID:  page_q[1] <= rem_nxt;
						bmm_pkg::PAIR_HIGH: page_q[2] <= rem_nxt;
						default:            page_q[2] <= rem_nxt;
					endcase
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			pend_q <= res;
			dvd_q  <= (creg == bmm_pkg::CREG_RAM_CTRL) ? fc3_q : in_data.write_data;
			rem_q  <= '0;
			dsr_q  <= pages_eff;
			tgt_q  <= (creg == bmm_pkg::CREG_RAM_CTRL) ? bmm_pkg::PAIR_HIGH : creg - 2'd1;
		end else if (cmd.div_step) begin
			dvd_q <= {dvd_q[bmm_pkg::DATA_W-2:0], 1'b0};
			rem_q <= rem_nxt;
		end
		if (cmd.emit) begin
			out_q <= pend_q;
		end
	end

	assign out_data = out_q;

endmodule

// ===== src/banked_memory_mapper_core.sv =====
// ----------------------------------------------------------------------------
// banked_memory_mapper_core
// Maps 16-bit CPU accesses onto ROM pages, save RAM or system RAM.
// ----------------------------------------------------------------------------
// Input words (kind, address, write_data) arrive on in_valid/in_stall and
// one result word (region, offset, store_enable, sram_used) leaves on
// out_valid/out_stall for every input word, in order.
// A plain access goes from acceptance through the emit state into the output
// register, and no new word is taken until its result has been emitted. A write
// at 0xfffc-0xffff that loads a page first passes through the divide state:
// the page number is reduced modulo the ROM page count by a restoring remainder
// unit that retires one bit per cycle over the 8 bits of the page number.
// The result of an access reflects the mapping before that access; only
// sram_used already includes it.
// rom_pages is written on cfg_valid (cfg_ready is always high); the user must
// write it only while no word is in flight, the block does not enforce this.
// Reset loads the power-on mapping (pages 0, 1, 0, save RAM off) and a page
// count of one. While the receiver stalls, the result is held in the output
// register and one more word may be taken and finished behind it.
// ----------------------------------------------------------------------------
module banked_memory_mapper_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [bmm_pkg::PAGES_W-1:0] cfg_data,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  bmm_pkg::in_word_t           in_data,
	output logic                        out_valid,
	input  logic                        out_stall,
	output bmm_pkg::out_word_t          out_data
);

	bmm_pkg::cmd_t    cmd;
	bmm_pkg::status_t status;

	assign cfg_ready = 1'b1;

	bmm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	bmm_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.in_data   (in_data),
		.out_data  (out_data),
		.cmd       (cmd),
		.status    (status)
	);

endmodule
